// ----- hdl/ptw_pkg.sv -----
// ----------------------------------------------------------------------------
// ptw_pkg: shared types and codes of the three-level page table walker
// Entry layout, status and command codes, level numbering and small helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

    localparam int TABLE_COUNT_DEF = 64;

    localparam int FRAME_W  = 14;
    localparam int SLOT_W   = 3;
    localparam int ROOT_W   = 6;
    localparam int VADDR_W  = 14;
    localparam int OFF_W    = 5;
    localparam int PADDR_W  = FRAME_W + OFF_W;
    localparam int STATUS_W = 3;
    localparam int ACC_W    = 2;
    localparam int LEVEL_W  = 2;
    localparam int CNT_W    = FRAME_W + 1;

    // Stored entry: frame in 17:4, valid 3, read 2, write 1, execute 0
    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               valid;
        logic               rd;
        logic               wr;
        logic               ex;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Outcome of checking one fetched entry
    typedef struct packed {
        logic                done;
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  next_tbl;
    } t_chk;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_HIGH    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_L1      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_L2      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_L3      = 3'd4;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_DENIED  = 3'd6;
    localparam logic [STATUS_W-1:0] ST_WRITTEN = 3'd7;

    localparam logic CMD_TRANSLATE = 1'b0;
    localparam logic CMD_WRITE     = 1'b1;

    localparam logic [ACC_W-1:0] ACC_READ  = 2'd0;
    localparam logic [ACC_W-1:0] ACC_WRITE = 2'd1;
    localparam logic [ACC_W-1:0] ACC_EXEC  = 2'd2;

    localparam logic [LEVEL_W-1:0] LVL_1 = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_2 = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_3 = 2'd2;

    // Table index lies inside the store
    function automatic logic tbl_ok(input logic [FRAME_W-1:0] t,
                                    input logic [CNT_W-1:0] cnt);
        return {1'b0, t} < cnt;
    endfunction

    // Slot bits of the logical address used at each level
    function automatic logic [SLOT_W-1:0] slot_of(input logic [VADDR_W-1:0] a,
                                                  input logic [LEVEL_W-1:0] lvl);
        logic [SLOT_W-1:0] s;
        case (lvl)
            LVL_1:   s = a[13:11];
            LVL_2:   s = a[10:8];
            default: s = a[7:5];
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/three_level_page_table_walk_top.sv -----
// ----------------------------------------------------------------------------
// three_level_page_table_walk_top: three-level page table walker
// Holds a store of eight-entry page tables, loads entries and translates
// addresses by walking root, second and third level tables.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake                  | payload
//  s_axis   | in  | tvalid / tready            | tuser command, tdata fields
//  m_axis   | out | tvalid / tready            | tuser status, tdata result
//  cfg      | in  | valid / ready (always 1)   | root_table
//
//  A write item or an early fault goes straight to the output register; a walk
//  reads root, second and third level entries in turn until an entry ends it,
//  one level per cycle through the single store read port. After reset a clearing
//  pass zeroes all TABLE_COUNT*8 store entries while no item is accepted; cfg
//  writes are taken throughout. A result waits in the output register while
//  m_axis stalls, and no new item is accepted until that register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module three_level_page_table_walk_top #(
    parameter int TABLE_COUNT = ptw_pkg::TABLE_COUNT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // cfg
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ptw_pkg::ROOT_W-1:0]    i_cfg_data,
    // input items
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // access_type[1:0], virt_addr[33:2], target_table[39:34],
    // target_slot[42:40], new_frame[56:43], new_valid[57], new_readable[58],
    // new_writable[59], new_executable[60], zero[63:61]
    input  wire logic [63:0]                   i_s_axis_tdata,
    // command[0]
    input  wire logic                          i_s_axis_tuser,
    // result items
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // phys_addr[18:0], pfn[32:19], grant_read[33],
    // grant_write[34], grant_execute[35], zero[39:36]
    output logic [39:0]                        o_m_axis_tdata,
    // status[2:0]
    output logic [ptw_pkg::STATUS_W-1:0]       o_m_axis_tuser
);

    import ptw_pkg::*;

    localparam int TBL_W  = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
    localparam int ADDR_W = TBL_W + SLOT_W;
    localparam int DEPTH  = TABLE_COUNT * 8;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_CHECK = 3'b100
    } t_state;

    // input fields
    logic [ACC_W-1:0]   in_access;
    logic [31:0]        in_laddr;
    logic [ROOT_W-1:0]  in_table;
    logic [SLOT_W-1:0]  in_slot;
    t_entry             in_entry;
    logic               in_cmd;

    assign in_access = i_s_axis_tdata[1:0];
    assign in_laddr  = i_s_axis_tdata[33:2];
    assign in_table  = i_s_axis_tdata[39:34];
    assign in_slot   = i_s_axis_tdata[42:40];
    assign in_entry  = '{frame: i_s_axis_tdata[56:43], valid: i_s_axis_tdata[57],
                         rd: i_s_axis_tdata[58], wr: i_s_axis_tdata[59],
                         ex: i_s_axis_tdata[60]};
    assign in_cmd    = i_s_axis_tuser;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_clr_addr, n_clr_addr;
    logic [ROOT_W-1:0]   r_root;
    logic [LEVEL_W-1:0]  r_level, n_level;
    logic [VADDR_W-1:0]  r_vaddr, n_vaddr;
    logic [ACC_W-1:0]    r_access, n_access;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    t_entry              r_out_entry, n_out_entry;
    logic [OFF_W-1:0]    r_out_off, n_out_off;

    logic                ram_we, ram_re;
    logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
    logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
    t_entry              rd_entry;
    t_chk                chk;
    logic                out_free, in_acc;

    assign rd_entry = t_entry'(ram_rdata);

    ptw_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    ptw_level_check #(
        .TABLE_COUNT (TABLE_COUNT)
    ) u_check (
        .i_entry  (rd_entry),
        .i_level  (r_level),
        .i_access (r_access),
        .o_res    (chk)
    );

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE) && out_free;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_level      = r_level;
        n_vaddr      = r_vaddr;
        n_access     = r_access;
        n_out_valid  = r_out_valid && !i_m_axis_tready;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        n_out_off    = r_out_off;
        ram_we       = 1'b0;
        ram_waddr    = r_clr_addr;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = {TBL_W'(r_root), slot_of(in_laddr[VADDR_W-1:0], LVL_1)};

        case (r_state)
            S_CLEAR: begin
                ram_we     = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_out_entry = '0;
                    n_out_off   = '0;
                    if (in_cmd == CMD_WRITE) begin
                        n_out_valid = 1'b1;
                        if (tbl_ok(FRAME_W'(in_table), CNT_W'(TABLE_COUNT))) begin
                            ram_we       = 1'b1;
                            ram_waddr    = {TBL_W'(in_table), in_slot};
                            ram_wdata    = in_entry;
                            n_out_status = ST_WRITTEN;
                        end else begin
                            n_out_status = ST_RANGE;
                        end
                    end else if (|in_laddr[31:VADDR_W]) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_HIGH;
                    end else if (!tbl_ok(FRAME_W'(r_root), CNT_W'(TABLE_COUNT))) begin
                        n_out_valid  = 1'b1;
                        n_out_status = ST_RANGE;
                    end else begin
                        // fetch the root table entry now
                        ram_re   = 1'b1;
                        n_vaddr  = in_laddr[VADDR_W-1:0];
                        n_access = in_access;
                        n_level  = LVL_1;
                        n_state  = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (!chk.done) begin
                    // advance to the next level table
                    ram_re    = 1'b1;
                    ram_raddr = {chk.next_tbl[TBL_W-1:0],
                                 slot_of(r_vaddr, r_level + 1'b1)};
                    n_level   = r_level + 1'b1;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = chk.status;
                    n_out_entry  = (chk.status == ST_OK) ? rd_entry : '0;
                    n_out_off    = (chk.status == ST_OK) ? r_vaddr[OFF_W-1:0] : '0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_root      <= '0;
            r_level     <= LVL_1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_level     <= n_level;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid) begin
                r_root <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_vaddr      <= n_vaddr;
        r_access     <= n_access;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
        r_out_off    <= n_out_off;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {4'd0, r_out_entry.ex, r_out_entry.wr, r_out_entry.rd,
                              r_out_entry.frame, r_out_entry.frame, r_out_off};

endmodule

`default_nettype wire

// ----- hdl/ptw_ram.sv -----
// ----------------------------------------------------------------------------
// ptw_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_ram #(
    parameter int WIDTH  = 18,
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ptw_level_check.sv -----
// ----------------------------------------------------------------------------
// ptw_level_check: entry check unit shared by all three walk levels
// Decides fault, next table pointer or final permission for one entry.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_level_check #(
    parameter int TABLE_COUNT = ptw_pkg::TABLE_COUNT_DEF
) (
    input  wire ptw_pkg::t_entry              i_entry,
    input  wire logic [ptw_pkg::LEVEL_W-1:0]  i_level,
    input  wire logic [ptw_pkg::ACC_W-1:0]    i_access,
    output ptw_pkg::t_chk                     o_res
);

    import ptw_pkg::*;

    logic allowed;

    always_comb begin
        case (i_access)
            ACC_READ:  allowed = i_entry.rd;
            ACC_WRITE: allowed = i_entry.wr;
            ACC_EXEC:  allowed = i_entry.ex;
            default:   allowed = 1'b0;
        endcase
    end

    always_comb begin
        o_res.done     = 1'b1;
        o_res.status   = ST_OK;
        o_res.next_tbl = i_entry.frame;
        if (!i_entry.valid) begin
            case (i_level)
                LVL_1:   o_res.status = ST_L1;
                LVL_2:   o_res.status = ST_L2;
                default: o_res.status = ST_L3;
            endcase
        end else if (i_level != LVL_3) begin
            // pointer to the next table must stay inside the store
            if (tbl_ok(i_entry.frame, CNT_W'(TABLE_COUNT))) begin
                o_res.done = 1'b0;
            end else begin
                o_res.status = ST_RANGE;
            end
        end else if (!allowed) begin
            o_res.status = ST_DENIED;
        end
    end

endmodule

`default_nettype wire
